/* sv/byte_ring_buffer_unit_macros.svh */
// Assertion helpers shared by the ring buffer RTL.
`ifndef BYTE_RING_BUFFER_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/brb_pkg.sv */
`default_nettype none

package brb_pkg;

    typedef enum logic [2:0] {
        ACT_WRITE  = 3'd0,
        ACT_READ   = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_SKIP   = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_STATUS = 3'd5
    } t_action;

    typedef enum logic [0:0] {
        S_IDLE   = 1'b0,
        S_RESULT = 1'b1
    } t_state;

    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 10;
    localparam int CFG_W    = 11;

endpackage

`default_nettype wire

/* sv/byte_ring_buffer_unit.sv */
`default_nettype none

// Byte ring FIFO. Each request (start high while busy is low) is one action:
// write, read, peek, skip, clear or status. Its result appears in the cycle
// after the request is taken, on the o_ ports for a single cycle with
// o_done high; the receiver cannot stall it, so it must capture the result
// in that cycle. A request first accesses the byte store, whose read data is
// registered, and then presents the result, during which busy is high.
// The size register (i_cfg_we / i_cfg_wdata) is clamped to
// [2, DEPTH] and empties the FIFO when written; write it only while idle.
// Capacity is size - 1 bytes. Every result reports fill, free space and the
// contiguous readable run up to the wrap point, all after the request.

module byte_ring_buffer_unit #(
    parameter int DEPTH = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [brb_pkg::ACTION_W-1:0] i_action,
    input  wire logic [brb_pkg::BYTE_W-1:0]   i_write_byte,
    input  wire logic [brb_pkg::COUNT_W-1:0]  i_peek_offset,
    input  wire logic [brb_pkg::COUNT_W-1:0]  i_skip_amount,
    // size register
    input  wire logic                         i_cfg_we,
    input  wire logic [brb_pkg::CFG_W-1:0]    i_cfg_wdata,
    // result channel
    output logic                              o_done,
    output logic [brb_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                              o_accepted,
    output logic [brb_pkg::COUNT_W-1:0]       o_amount_done,
    output logic [brb_pkg::COUNT_W-1:0]       o_fill_level,
    output logic [brb_pkg::COUNT_W-1:0]       o_free_space,
    output logic [brb_pkg::COUNT_W-1:0]       o_linear_length
);
    import brb_pkg::*;

    // IW: store address width; SW: holds DEPTH itself; AW: working width for
    // sums of an index and a 10/11-bit field.
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH + 1);
    localparam int AW = ((SW > CFG_W) ? SW : CFG_W) + 1;

    localparam logic [AW-1:0] DEPTH_A   = AW'(DEPTH);
    localparam logic [AW-1:0] MIN_SIZE  = AW'(2);
    localparam logic [SW-1:0] SIZE_RST  = SW'((DEPTH < 1024) ? DEPTH : 1024);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state            r_state, n_state;
    logic [IW-1:0]     r_wr_idx, n_wr_idx;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [SW-1:0]     r_size, n_size;

    // result registers (payload, no reset)
    logic                r_acc, n_acc;
    logic                r_byte_sel, n_byte_sel;
    logic [COUNT_W-1:0]  r_amount, n_amount;
    logic [BYTE_W-1:0]   r_mem_q;

    // byte store
    logic [BYTE_W-1:0]   mem [DEPTH];
    logic                mem_we;
    logic                mem_re;
    logic [IW-1:0]       mem_addr;

    // ---------------------------------------------------------------
    // Arithmetic on the current indices
    // ---------------------------------------------------------------
    logic            req;
    logic [AW-1:0]   size_a, wr_a, rd_a, fill_a, free_a, linear_a;
    logic [AW-1:0]   cfg_a;
    logic [AW-1:0]   wr_inc, rd_inc;
    logic [AW-1:0]   peek_sum, peek_pos;
    logic [AW-1:0]   skip_a, skip_n, skip_sum, skip_pos;

    assign req    = start && !busy;
    assign size_a = AW'(r_size);
    assign wr_a   = AW'(r_wr_idx);
    assign rd_a   = AW'(r_rd_idx);

    // In the idle cycle these describe the state before a request; in the
    // result cycle the indices are already updated, so the same logic gives
    // the reported fill, free space and linear run.
    assign fill_a   = (wr_a >= rd_a) ? (wr_a - rd_a) : (size_a - (rd_a - wr_a));
    assign free_a   = size_a - AW'(1) - fill_a;
    assign linear_a = (wr_a > rd_a) ? (wr_a - rd_a) :
                      (rd_a > wr_a) ? (size_a - rd_a) : '0;

    assign wr_inc = wr_a + AW'(1);
    assign rd_inc = rd_a + AW'(1);

    // peek position wraps at most once since offset < fill < size
    assign peek_sum = rd_a + AW'(i_peek_offset);
    assign peek_pos = (peek_sum >= size_a) ? (peek_sum - size_a) : peek_sum;

    assign skip_a   = AW'(i_skip_amount);
    assign skip_n   = (skip_a < fill_a) ? skip_a : fill_a;
    assign skip_sum = rd_a + skip_n;
    assign skip_pos = (skip_sum >= size_a) ? (skip_sum - size_a) : skip_sum;

    // clamp of a size write to [2, DEPTH]
    assign cfg_a  = AW'(i_cfg_wdata);
    assign n_size = (cfg_a < MIN_SIZE) ? MIN_SIZE[SW-1:0] :
                    (cfg_a > DEPTH_A)  ? DEPTH_A[SW-1:0]  : cfg_a[SW-1:0];

    // ---------------------------------------------------------------
    // Action decode
    // ---------------------------------------------------------------
    always_comb begin
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_acc      = 1'b0;
        n_byte_sel = 1'b0;
        n_amount   = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_wr_idx;
        unique case (t_action'(i_action))
            ACT_WRITE: begin
                if (fill_a < (size_a - AW'(1))) begin
                    mem_we   = req;
                    n_wr_idx = (wr_inc == size_a) ? '0 : wr_inc[IW-1:0];
                    n_acc    = 1'b1;
                    n_amount = COUNT_W'(1);
                end
            end
            ACT_READ: begin
                mem_addr = r_rd_idx;
                if (fill_a != '0) begin
                    mem_re     = req;
                    n_rd_idx   = (rd_inc == size_a) ? '0 : rd_inc[IW-1:0];
                    n_acc      = 1'b1;
                    n_byte_sel = 1'b1;
                    n_amount   = COUNT_W'(1);
                end
            end
            ACT_PEEK: begin
                mem_addr = peek_pos[IW-1:0];
                if (AW'(i_peek_offset) < fill_a) begin
                    mem_re     = req;
                    n_acc      = 1'b1;
                    n_byte_sel = 1'b1;
                end
            end
            ACT_SKIP: begin
                n_rd_idx = skip_pos[IW-1:0];
                n_amount = skip_n[COUNT_W-1:0];
            end
            ACT_CLEAR: begin
                n_wr_idx = '0;
                n_rd_idx = '0;
            end
            default: begin
                // status and unused codes: nothing changes
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Byte store: one port, registered read
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_write_byte;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_addr];
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_comb begin
        unique case (r_state)
            S_IDLE:   n_state = req ? S_RESULT : S_IDLE;
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_RESULT: begin
                busy   = 1'b1;
                o_done = 1'b1;
            end
            default: begin
                busy   = 1'b0;
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_size   <= SIZE_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                // size change empties the FIFO
                r_size   <= n_size;
                r_wr_idx <= '0;
                r_rd_idx <= '0;
            end else if (req) begin
                r_wr_idx <= n_wr_idx;
                r_rd_idx <= n_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req) begin
            r_acc      <= n_acc;
            r_byte_sel <= n_byte_sel;
            r_amount   <= n_amount;
        end
    end

    // ---------------------------------------------------------------
    // Result ports
    // ---------------------------------------------------------------
    assign o_read_byte     = r_byte_sel ? r_mem_q : '0;
    assign o_accepted      = r_acc;
    assign o_amount_done   = r_amount;
    assign o_fill_level    = fill_a[COUNT_W-1:0];
    assign o_free_space    = free_a[COUNT_W-1:0];
    assign o_linear_length = linear_a[COUNT_W-1:0];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "byte_ring_buffer_unit_macros.svh"

    `BRB_ASSERT_NEXT(a_result_follows, req, o_done, "request without result next cycle")
    `BRB_ASSERT_NOW(a_idx_in_range, 1'b1, (wr_a < size_a) && (rd_a < size_a), "index beyond size")
    `BRB_ASSERT_NOW(a_fill_free_sum, o_done, fill_a + free_a == size_a - AW'(1), "fill plus free")
    `BRB_ASSERT_NOW(a_byte_only_read, !o_accepted && o_done, o_read_byte == '0, "byte on refusal")

endmodule

`default_nettype wire
